[src/pam_pkg.sv]
// pam_pkg: shared constants for the paging map with bitmap allocator
// field widths, opcodes, status codes and parameter defaults; no dependencies
`default_nettype none
package pam_pkg;

  localparam int OP_W     = 2;
  localparam int OBJ_W    = 2;
  localparam int PAGE_W   = 16;
  localparam int STAT_W   = 3;
  localparam int BIDX_W   = 10;
  localparam int FREED_W  = 9;
  localparam int FREE_W   = 11;
  localparam int LIMIT_W  = 11;
  localparam int IN_TW    = 24;
  localparam int OUT_TW   = 40;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  localparam int DEF_BLOCKS    = 1024;
  localparam int DEF_OBJECTS   = 4;
  localparam int DEF_MAP_PAGES = 256;
  localparam int LIMIT_RESET   = 1024;

  localparam logic [OP_W-1:0] OP_READ    = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_BLOCK = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_RELEASED = 3'd4;

endpackage
`default_nettype wire

[src/paging_map_with_bitmap_allocator.sv]
// paging_map_with_bitmap_allocator: per-object page map over a shared block bitmap
// uses pam_pkg and two pam_ram instances (page map, bitmap words)
//
//  channel | direction | handshake            | content
//  in_     | input     | tvalid/tready        | opcode, object_id, page_index
//  out_    | output    | tvalid/tready        | status, block_index, freed_count, free_blocks
//  cfg_    | input     | apb psel/penable     | partition_blocks at address 0
//
// read and write pass through acceptance, the page map and bitmap word reads
// (both returned together by the registered rams), and the result load.
// release walks the object's map page by page, clearing each mapped entry
// and then its block's bitmap bit. after reset a clearing pass zeroes both
// rams; no transaction is accepted until it ends.
// a waiting result does not block acceptance of the next input; that transaction
// holds in the response state until the output register empties.
`default_nettype none
module paging_map_with_bitmap_allocator #(
  parameter int BLOCKS    = pam_pkg::DEF_BLOCKS,
  parameter int OBJECTS   = pam_pkg::DEF_OBJECTS,
  parameter int MAP_PAGES = pam_pkg::DEF_MAP_PAGES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // opcode[1:0], object_id[3:2], page_index[19:4], zero fill
  input  wire logic [pam_pkg::IN_TW-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // status[2:0], block_index[12:3], freed_count[21:13], free_blocks[32:22], zero fill
  output logic      [pam_pkg::OUT_TW-1:0]    out_tdata,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [pam_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [pam_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [pam_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import pam_pkg::*;

  localparam int PT_D     = OBJECTS * MAP_PAGES;
  localparam int PT_AW    = $clog2(PT_D);
  localparam int BLK_W    = $clog2(BLOCKS);
  localparam int ENT_W    = BLK_W + 1;
  localparam int WORD_W   = (BLOCKS >= 32) ? 32 : 8;
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int BM_WORDS = (BLOCKS + WORD_W - 1) / WORD_W;
  localparam int BM_AW    = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
  localparam int CNT_W    = $clog2(BLOCKS + 1);
  localparam int PG_W     = $clog2(MAP_PAGES);
  localparam int FRC_W    = $clog2(MAP_PAGES + 1);
  localparam int CLR_N    = (PT_D > BM_WORDS) ? PT_D : BM_WORDS;
  localparam int CLR_W    = $clog2(CLR_N);
  localparam logic [CFG_AW-1:0] ADDR_LIMIT = '0;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_RCHK, S_RCLR, S_RESP
  } state_t;

  state_t                state_r;
  logic [CLR_W-1:0]      clr_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic [CNT_W-1:0]      used_r;
  logic [BM_WORDS-1:0]   full_r;
  logic [OP_W-1:0]       op_r;
  logic [PT_AW-1:0]      base_r;
  logic [PG_W-1:0]       idx_r;
  logic [BM_AW-1:0]      wsel_r;
  logic                  nfree_r;
  logic [BLK_W-1:0]      blk_r;
  logic [STAT_W-1:0]     st_r;
  logic [FRC_W-1:0]      freed_r;
  logic                  out_valid_r;
  logic [OUT_TW-1:0]     out_data_r;

  // ram ports
  logic                  pt_we;
  logic [PT_AW-1:0]      pt_waddr, pt_raddr;
  logic [ENT_W-1:0]      pt_wdata, pt_rdata;
  logic                  bm_we;
  logic [BM_AW-1:0]      bm_waddr, bm_raddr;
  logic [WORD_W-1:0]     bm_wdata, bm_rdata;

  pam_ram #(.W(ENT_W), .D(PT_D), .AW(PT_AW)) u_pt_ram (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  pam_ram #(.W(WORD_W), .D(BM_WORDS), .AW(BM_AW)) u_bm_ram (
    .clk, .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  logic [OP_W-1:0]   in_op;
  logic [OBJ_W-1:0]  in_obj;
  logic [PAGE_W-1:0] in_page;
  logic              in_acc, in_bad;
  logic [PT_AW-1:0]  in_base;
  logic [31:0]       lim, free_left, cand;
  logic [BM_AW-1:0]  wsel;
  logic              nfree;
  logic [BIT_W-1:0]  zbit;
  logic              zfound;
  logic              last_pg;
  logic [PT_AW-1:0]  next_addr;
  logic [BM_AW-1:0]  rel_word;
  logic [BIT_W-1:0]  rel_bit;
  logic              cfg_wr;

  assign in_op   = in_tdata[1:0];
  assign in_obj  = in_tdata[3:2];
  assign in_page = in_tdata[19:4];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc  = in_tvalid && in_tready;
  assign in_bad  = (32'(in_obj) >= 32'(OBJECTS)) || (in_op != OP_READ && in_op != OP_WRITE &&
                   in_op != OP_RELEASE) ||
                   (in_op != OP_RELEASE && 32'(in_page) >= 32'(MAP_PAGES));
  assign in_base = PT_AW'(32'(in_obj) * 32'(MAP_PAGES));

  assign lim       = (32'(limit_r) > 32'(BLOCKS)) ? 32'(BLOCKS) : 32'(limit_r);
  assign free_left = (32'(used_r) >= lim) ? 32'd0 : lim - 32'(used_r);

  assign last_pg   = (32'(idx_r) == 32'(MAP_PAGES - 1));
  assign next_addr = base_r + PT_AW'(idx_r) + PT_AW'(1);
  assign rel_word  = BM_AW'(blk_r >> BIT_W);
  assign rel_bit   = blk_r[BIT_W-1:0];

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_LIMIT) ? CFG_DW'(limit_r) : '0;

  // lowest word that still has a clear bit
  always_comb begin
    wsel  = '0;
    nfree = 1'b0;
    for (int k = BM_WORDS - 1; k >= 0; k--) begin
      if (!full_r[k]) begin
        wsel  = BM_AW'(k);
        nfree = 1'b1;
      end
    end
  end

  // lowest clear bit of the word just read
  always_comb begin
    zbit   = '0;
    zfound = 1'b0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (!bm_rdata[k]) begin
        zbit   = BIT_W'(k);
        zfound = 1'b1;
      end
    end
  end

  assign cand = 32'(wsel_r) * 32'(WORD_W) + 32'(zbit);

  always_comb begin
    pt_raddr = next_addr;
    if (state_r == S_IDLE) begin
      pt_raddr = (in_op == OP_RELEASE) ? in_base : in_base + PT_AW'(in_page);
    end
    bm_raddr = rel_word;
    if (state_r == S_IDLE) begin
      bm_raddr = wsel;
    end else if (state_r == S_RCHK) begin
      // fetch the bitmap word of the block about to be freed
      bm_raddr = BM_AW'(pt_rdata[BLK_W-1:0] >> BIT_W);
    end

    pt_we    = 1'b0;
    pt_waddr = base_r + PT_AW'(idx_r);
    pt_wdata = '0;
    bm_we    = 1'b0;
    bm_waddr = wsel_r;
    bm_wdata = bm_rdata;
    case (state_r)
      S_CLEAR: begin
        pt_we    = (32'(clr_r) < 32'(PT_D));
        pt_waddr = PT_AW'(clr_r);
        bm_we    = (32'(clr_r) < 32'(BM_WORDS));
        bm_waddr = BM_AW'(clr_r);
        bm_wdata = '0;
      end
      S_LOOK: begin
        if (!pt_rdata[ENT_W-1] && op_r == OP_WRITE && 32'(used_r) < lim &&
            nfree_r && zfound && cand < lim) begin
          pt_we    = 1'b1;
          pt_waddr = base_r;
          pt_wdata = {1'b1, BLK_W'(cand)};
          bm_we    = 1'b1;
          bm_wdata = bm_rdata | (WORD_W'(1) << zbit);
        end
      end
      S_RCHK: begin
        pt_we = pt_rdata[ENT_W-1];
      end
      S_RCLR: begin
        bm_we    = 1'b1;
        bm_waddr = rel_word;
        bm_wdata = bm_rdata & ~(WORD_W'(1) << rel_bit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      limit_r     <= LIMIT_W'(LIMIT_RESET);
      used_r      <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        limit_r <= cfg_pwdata[LIMIT_W-1:0];
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLR_W'(1);
          if (32'(clr_r) == 32'(CLR_N - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= in_op;
            base_r  <= (in_op == OP_RELEASE) ? in_base : in_base + PT_AW'(in_page);
            idx_r   <= '0;
            wsel_r  <= wsel;
            nfree_r <= nfree;
            freed_r <= '0;
            blk_r   <= '0;
            if (in_bad) begin
              st_r    <= ST_RANGE;
              state_r <= S_RESP;
            end else if (in_op == OP_RELEASE) begin
              state_r <= S_RCHK;
            end else begin
              state_r <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          state_r <= S_RESP;
          if (pt_rdata[ENT_W-1]) begin
            st_r  <= ST_FOUND;
            blk_r <= pt_rdata[BLK_W-1:0];
          end else if (op_r == OP_READ) begin
            st_r <= ST_NO_BLOCK;
          end else if (bm_we) begin
            st_r           <= ST_FOUND;
            blk_r          <= BLK_W'(cand);
            used_r         <= used_r + CNT_W'(1);
            full_r[wsel_r] <= &bm_wdata;
          end else begin
            st_r <= ST_NO_SPACE;
          end
        end
        S_RCHK: begin
          if (pt_rdata[ENT_W-1]) begin
            blk_r   <= pt_rdata[BLK_W-1:0];
            freed_r <= freed_r + FRC_W'(1);
            state_r <= S_RCLR;
          end else if (last_pg) begin
            st_r    <= ST_RELEASED;
            state_r <= S_RESP;
          end else begin
            idx_r <= idx_r + PG_W'(1);
          end
        end
        S_RCLR: begin
          if (bm_rdata[rel_bit] && used_r != '0) begin
            used_r <= used_r - CNT_W'(1);
          end
          full_r[rel_word] <= 1'b0;
          blk_r            <= '0;
          if (last_pg) begin
            st_r    <= ST_RELEASED;
            state_r <= S_RESP;
          end else begin
            idx_r   <= idx_r + PG_W'(1);
            state_r <= S_RCHK;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {7'd0, FREE_W'(free_left), FREED_W'(freed_r),
                            (st_r == ST_FOUND) ? BIDX_W'(blk_r) : BIDX_W'(0), st_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

[src/pam_ram.sv]
// pam_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies
`default_nettype none
module pam_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
